@@ rtl/core/adaptive_load_predictor_macros.svh @@
// Assertion macros shared by the adaptive load predictor RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ADAPTIVE_LOAD_PREDICTOR_MACROS_SVH
`define ADAPTIVE_LOAD_PREDICTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ALP_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ALP_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/alp_pkg.sv @@
// Package of the adaptive load predictor: widths, reset values, codes and
// the command and status types between controller and datapath. No dependencies.
`default_nettype none

package alp_pkg;

    localparam int DATA_W         = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int WINDOW_DEFAULT = 5;
    localparam int MUL_W          = DATA_W + 1;
    localparam int PROD_W         = 2 * MUL_W;

    localparam logic [DATA_W-1:0] RESET_GAIN    = 16'd32768;
    localparam logic [DATA_W-1:0] RESET_INIT    = 16'd13;
    localparam logic [DATA_W-1:0] LOAD_MAX      = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMOOTHING_GAIN = 2'd0,
        CFG_INITIAL_FACTOR = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        REL_BELOW = 2'd0,
        REL_ABOVE = 2'd1,
        REL_EQUAL = 2'd2
    } rel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN,
        ST_UPDATE,
        ST_SCALE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic capture;
        logic mul_gain;
        logic update;
        logic mul_load;
        logic load_out;
    } alp_cmd_t;

    typedef struct packed {
        logic out_free;
    } alp_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/alp_datapath.sv @@
// Datapath of the adaptive load predictor: configuration registers, sample
// and window state, the shared multiplier and the output word register.
// Depends on alp_pkg.
`default_nettype none

module alp_datapath
    import alp_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [DATA_W-1:0]     s_load_sample,
    input  wire logic                  m_ready,
    output logic                       m_valid,
    output logic [DATA_W-1:0]          m_predicted_load,
    output logic                       m_prediction_valid,
    output logic [1:0]                 m_mean_relation,
    input  wire alp_cmd_t              cmd,
    output alp_sts_t                   sts
);

    localparam int SEEN_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = DATA_W + $clog2(WINDOW);

    logic [DATA_W-1:0] gain_reg, gain_next;
    logic [DATA_W-1:0] init_reg, init_next;
    logic [DATA_W-1:0] x_reg, x_next;
    logic              first_reg, first_next;
    logic              warm_reg, warm_next;
    rel_t              rel_reg, rel_next;
    logic [DATA_W-1:0] prev_reg, prev_next;
    logic [DATA_W-1:0] factor_reg, factor_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_pred_reg, out_pred_next;
    logic              out_pvalid_reg, out_pvalid_next;
    rel_t              out_rel_reg, out_rel_next;

    logic [DATA_W-1:0]        diff;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W+1:0] step_acc;
    logic signed [DATA_W+2:0] factor_sum;
    logic [SUM_W-1:0]         scaled;
    logic [32:0]              round_sum;
    logic [24:0]              product_q;
    logic [25:0]              sat_sum;
    logic [DATA_W-1:0]        pred;

    always_comb begin
        gain_next = gain_reg;
        init_next = init_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_SMOOTHING_GAIN: gain_next = cfg_data;
                CFG_INITIAL_FACTOR: init_next = cfg_data;
                default: ;
            endcase
        end
    end

    assign diff = (x_reg > prev_reg) ? (x_reg - prev_reg) : (prev_reg - x_reg);

    always_comb begin
        if (cmd.mul_gain) begin
            mul_a = $signed({1'b0, diff}) - $signed({1'b0, factor_reg});
            mul_b = $signed({1'b0, gain_reg});
        end else begin
            mul_a = $signed({1'b0, x_reg});
            mul_b = $signed({1'b0, factor_reg});
        end
    end

    assign prod_next = (cmd.mul_gain || cmd.mul_load) ? (mul_a * mul_b) : prod_reg;

    // The smoothing step is factor + round((diff - factor) * gain / 2^16).
    assign step_acc   = PROD_W'(prod_reg) + (PROD_W + 2)'(32768);
    assign factor_sum = $signed({3'b000, factor_reg}) + (DATA_W + 3)'(step_acc >>> 16);

    assign scaled = SUM_W'(x_reg) * SUM_W'(WINDOW);

    always_comb begin
        x_next      = cmd.capture ? s_load_sample : x_reg;
        first_next  = cmd.capture ? (seen_reg == '0) : first_reg;
        warm_next   = cmd.capture ? (seen_reg != SEEN_W'(WINDOW)) : warm_reg;
        rel_next    = rel_reg;
        if (cmd.mul_gain) begin
            if (scaled < sum_reg) begin
                rel_next = REL_BELOW;
            end else if (scaled > sum_reg) begin
                rel_next = REL_ABOVE;
            end else begin
                rel_next = REL_EQUAL;
            end
        end
        prev_next   = prev_reg;
        factor_next = factor_reg;
        sum_next    = sum_reg;
        seen_next   = seen_reg;
        if (cmd.update) begin
            prev_next   = x_reg;
            factor_next = first_reg ? init_reg : factor_sum[DATA_W-1:0];
            if (warm_reg) begin
                sum_next  = sum_reg + SUM_W'(x_reg);
                seen_next = seen_reg + SEEN_W'(1);
            end
        end
    end

    assign round_sum = {1'b0, prod_reg[31:0]} + 33'd128;
    assign product_q = round_sum[32:8];
    assign sat_sum   = {10'b0, x_reg} + {1'b0, product_q};

    always_comb begin
        case (rel_reg)
            REL_BELOW: pred = (sat_sum > 26'(LOAD_MAX)) ? LOAD_MAX : sat_sum[DATA_W-1:0];
            REL_ABOVE: pred = (product_q >= 25'(x_reg)) ? '0 : (x_reg - product_q[DATA_W-1:0]);
            default:   pred = x_reg;
        endcase
    end

    always_comb begin
        out_pred_next   = out_pred_reg;
        out_pvalid_next = out_pvalid_reg;
        out_rel_next    = out_rel_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        if (cmd.load_out) begin
            out_valid_next  = 1'b1;
            out_pred_next   = warm_reg ? '0 : pred;
            out_pvalid_next = !warm_reg;
            out_rel_next    = warm_reg ? REL_EQUAL : rel_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg      <= RESET_GAIN;
            init_reg      <= RESET_INIT;
            sum_reg       <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            gain_reg      <= gain_next;
            init_reg      <= init_next;
            sum_reg       <= sum_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg          <= x_next;
        first_reg      <= first_next;
        warm_reg       <= warm_next;
        rel_reg        <= rel_next;
        prev_reg       <= prev_next;
        factor_reg     <= factor_next;
        prod_reg       <= prod_next;
        out_pred_reg   <= out_pred_next;
        out_pvalid_reg <= out_pvalid_next;
        out_rel_reg    <= out_rel_next;
    end

    assign sts.out_free       = !out_valid_reg || m_ready;
    assign m_valid            = out_valid_reg;
    assign m_predicted_load   = out_pred_reg;
    assign m_prediction_valid = out_pvalid_reg;
    assign m_mean_relation    = out_rel_reg;

endmodule

`default_nettype wire

@@ rtl/core/alp_ctrl.sv @@
// Controller of the adaptive load predictor: sequences one sample through
// the datapath. Depends on alp_pkg and adaptive_load_predictor_macros.svh.
`default_nettype none

`include "adaptive_load_predictor_macros.svh"

module alp_ctrl
    import alp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output alp_cmd_t      cmd,
    input  wire alp_sts_t sts
);

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_GAIN;
            ST_GAIN:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_RESULT;
            ST_RESULT: if (sts.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_GAIN:   cmd.mul_gain = 1'b1;
            ST_UPDATE: cmd.update   = 1'b1;
            ST_SCALE:  cmd.mul_load = 1'b1;
            ST_RESULT: cmd.load_out = sts.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `ALP_ASSERT_SAME(a_one_command, aclk, aresetn, 1'b1, $onehot0(cmd), "more than one command")
    `ALP_ASSERT_NEXT(a_capture_to_gain, aclk, aresetn, cmd.capture, state_reg == ST_GAIN, "capture not followed by gain step")
    `ALP_ASSERT_SAME(a_load_when_free, aclk, aresetn, cmd.load_out, sts.out_free, "output word overwritten")
    `ALP_ASSERT_NEXT(a_update_to_scale, aclk, aresetn, cmd.update, cmd.mul_load, "factor update not followed by load multiply")

endmodule

`default_nettype wire

@@ rtl/core/adaptive_load_predictor.sv @@
// Top level of the adaptive load predictor: joins controller and datapath.
// Depends on alp_pkg, alp_ctrl and alp_datapath.
//
// Each accepted load sample word (unsigned Q8.8) yields exactly one result word.
// A sample holds the controller through the idle state in which it is accepted,
// the gain multiply, the factor update, the load-times-factor multiply and the
// result step; the two multiplies share one 17 by 17 bit signed multiplier.
// The result step loads the result word into the output register, and the next
// sample is accepted only after that step. s_ready is high only while the
// controller is idle; a finished result waits in its own output register, so
// the next sample is taken while that result is still pending. The result step
// stalls while the output register still holds a word the receiver has not
// taken. The first WINDOW samples after reset fill the mean window and give a
// prediction of zero with m_prediction_valid low. Configuration words go
// through cfg_we, cfg_index and cfg_data; index 0 is the smoothing gain and
// index 1 the initial factor, other indexes are ignored.
`default_nettype none

module adaptive_load_predictor
    import alp_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [DATA_W-1:0]     s_load_sample,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [DATA_W-1:0]          m_predicted_load,
    output logic                       m_prediction_valid,
    output logic [1:0]                 m_mean_relation
);

    alp_cmd_t cmd;
    alp_sts_t sts;

    alp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    alp_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_load_sample      (s_load_sample),
        .m_ready            (m_ready),
        .m_valid            (m_valid),
        .m_predicted_load   (m_predicted_load),
        .m_prediction_valid (m_prediction_valid),
        .m_mean_relation    (m_mean_relation),
        .cmd                (cmd),
        .sts                (sts)
    );

endmodule

`default_nettype wire

@@ tb/sv/adaptive_load_predictor_tb.sv @@
// Self-checking testbench for adaptive_load_predictor: directed and random load
// sample words with random idling, backpressure and register phases.
// Depends on alp_pkg and the adaptive_load_predictor RTL.
`default_nettype none

module adaptive_load_predictor_tb;
    import alp_pkg::*;

    localparam int LOAD_WINDOW  = WINDOW_DEFAULT;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 100000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic [DATA_W-1:0] predicted_load;
        logic              prediction_valid;
        rel_t              mean_relation;
    } load_forecast_t;

    logic                  aclk;
    logic                  aresetn            = 1'b0;
    logic                  cfg_we             = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index          = '0;
    logic [CFG_DATA_W-1:0] cfg_data           = '0;
    logic                  s_valid            = 1'b0;
    logic                  s_ready;
    logic [DATA_W-1:0]     s_load_sample      = '0;
    logic                  m_valid;
    logic                  m_ready            = 1'b0;
    logic [DATA_W-1:0]     m_predicted_load;
    logic                  m_prediction_valid;
    logic [1:0]            m_mean_relation;

    // Shadow copy of the block's registers and state.
    logic [DATA_W-1:0] gain_reg      = RESET_GAIN;
    logic [DATA_W-1:0] init_reg      = RESET_INIT;
    logic [2:0]        seen_count    = '0;
    logic [18:0]       sum_of_window = '0;
    logic [DATA_W-1:0] prev_load     = '0;
    logic [DATA_W-1:0] factor        = RESET_INIT;

    load_forecast_t forecast_q[$];
    int unsigned    error_count     = 0;
    int unsigned    cycle_count     = 0;
    int unsigned    hold_off_cycles = 0;
    bit             idle_enable     = 1'b1;

    adaptive_load_predictor #(
        .WINDOW(LOAD_WINDOW)
    ) u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_load_sample     (s_load_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_predicted_load  (m_predicted_load),
        .m_prediction_valid(m_prediction_valid),
        .m_mean_relation   (m_mean_relation)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic load_forecast_t forecast_load(input logic [DATA_W-1:0] x);
        load_forecast_t    f;
        logic [DATA_W-1:0] diff;
        logic [47:0]       blend;
        logic [31:0]       scaled;
        logic [31:0]       prod;
        logic [31:0]       total;
        f.predicted_load   = '0;
        f.prediction_valid = 1'b0;
        f.mean_relation    = REL_EQUAL;
        if (seen_count == 0) begin
            factor = init_reg;
        end else begin
            diff  = (x > prev_load) ? x - prev_load : prev_load - x;
            blend = 48'(factor) * (48'd65536 - 48'(gain_reg)) + 48'(diff) * 48'(gain_reg)
                    + 48'd32768;
            factor = blend[31:16];
        end
        prev_load = x;
        if (seen_count < LOAD_WINDOW) begin
            sum_of_window = sum_of_window + 19'(x);
            seen_count    = seen_count + 3'd1;
        end else begin
            scaled = 32'(x) * LOAD_WINDOW;
            prod   = (32'(x) * 32'(factor) + 32'd128) >> 8;
            f.prediction_valid = 1'b1;
            if (scaled < 32'(sum_of_window)) begin
                total            = 32'(x) + prod;
                f.predicted_load = (total > 32'(LOAD_MAX)) ? LOAD_MAX : total[DATA_W-1:0];
                f.mean_relation  = REL_BELOW;
            end else if (scaled > 32'(sum_of_window)) begin
                f.predicted_load = (prod >= 32'(x)) ? '0 : x - prod[DATA_W-1:0];
                f.mean_relation  = REL_ABOVE;
            end else begin
                f.predicted_load = x;
                f.mean_relation  = REL_EQUAL;
            end
        end
        return f;
    endfunction

    // Most samples sit near the mean, at the range ends or close to the last word.
    function automatic logic [DATA_W-1:0] pick_load_sample();
        logic [DATA_W-1:0] mean_guess;
        mean_guess = 16'(sum_of_window / LOAD_WINDOW);
        case ($urandom_range(0, 5))
            0:       return mean_guess;
            1:       return mean_guess + 16'($urandom_range(0, 6)) - 16'd3;
            2:       return 16'($urandom_range(0, 255));
            3:       return 16'($urandom_range(65280, 65535));
            4:       return prev_load ^ 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("%0t: %s", $time, what);
    endtask

    task automatic send_sample(input logic [DATA_W-1:0] sample);
        int unsigned gap;
        gap = idle_enable ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_load_sample <= sample;
        do @(posedge aclk); while (!s_ready);
        forecast_q.push_back(forecast_load(sample));
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (forecast_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (index == CFG_SMOOTHING_GAIN) begin
            gain_reg = value;
        end else if (index == CFG_INITIAL_FACTOR) begin
            init_reg = value;
        end
        @(posedge aclk);
    endtask

    task automatic run_random_samples(input int count);
        repeat (count) send_sample(pick_load_sample());
    endtask

    // The warm-up words sum to a multiple of the window, so the mean is exact and
    // a sample equal to it is reachable.
    task automatic test_directed_cases();
        logic [DATA_W-1:0] loads [21] = '{
            16'd0, 16'd65535, 16'd100, 16'd65535, 16'd0,
            16'd26234, 16'd26233, 16'd26235, 16'd65535, 16'd0,
            16'd26234, 16'd26234, 16'd26234, 16'd26234,
            16'd26234, 16'd26234, 16'd26234, 16'd26234,
            16'd26100, 16'd26400, 16'd1
        };
        foreach (loads[i]) send_sample(loads[i]);
        wait_for_results();
    endtask

    task automatic test_register_phases();
        write_register(CFG_SMOOTHING_GAIN, 16'd0);
        write_register(CFG_INITIAL_FACTOR, 16'hFFFF);
        write_register(CFG_SPARE_A, 16'hFFFF);
        run_random_samples(100);
        wait_for_results();
        write_register(CFG_SMOOTHING_GAIN, 16'hFFFF);
        write_register(CFG_INITIAL_FACTOR, 16'd0);
        write_register(CFG_SPARE_B, 16'hA5A5);
        run_random_samples(100);
        wait_for_results();
        write_register(CFG_SMOOTHING_GAIN, 16'd1);
        run_random_samples(100);
        wait_for_results();
        write_register(CFG_SMOOTHING_GAIN, 16'($urandom));
        write_register(CFG_INITIAL_FACTOR, 16'($urandom));
        run_random_samples(100);
        wait_for_results();
        write_register(CFG_SMOOTHING_GAIN, RESET_GAIN);
        run_random_samples(100);
        wait_for_results();
    endtask

    task automatic test_output_backpressure();
        idle_enable     = 1'b0;
        hold_off_cycles = 150;
        run_random_samples(20);
        wait_for_results();
        idle_enable = 1'b1;
    endtask

    task automatic test_full_rate();
        idle_enable = 1'b0;
        run_random_samples(60);
        wait_for_results();
        idle_enable = 1'b1;
    endtask

    initial begin : result_receiver
        int unsigned stall;
        forever begin
            stall = idle_enable ? $urandom_range(0, 8) : 0;
            if (hold_off_cycles > 0) begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        load_forecast_t want;
        if (aresetn && m_valid && m_ready) begin
            if (forecast_q.size() == 0) begin
                report_mismatch("result word arrived with no prediction waiting");
            end else begin
                want = forecast_q.pop_front();
                if (m_predicted_load !== want.predicted_load) begin
                    report_mismatch($sformatf("predicted_load %0d, expected %0d",
                                              m_predicted_load, want.predicted_load));
                end
                if (m_prediction_valid !== want.prediction_valid) begin
                    report_mismatch($sformatf("prediction_valid %0b, expected %0b",
                                              m_prediction_valid, want.prediction_valid));
                end
                if (m_mean_relation !== want.mean_relation) begin
                    report_mismatch($sformatf("mean_relation %0d, expected %0d",
                                              m_mean_relation, want.mean_relation));
                end
            end
        end
    end

    initial begin : test_sequence
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_register_phases();
        test_output_backpressure();
        test_full_rate();
        wait_for_results();
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
